// ===== rtl/core/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the debounced button command qualifier.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int LEVEL_W = 3;
    localparam int ACT_W   = 2;
    localparam int MASK_W  = 3;
    localparam int MIS_W   = 2;

    // Field offsets inside the input word; tuser carries op alone
    localparam int IN_NOW_LO = 0;
    localparam int IN_LVL_LO = IN_NOW_LO + TIME_W;
    localparam int IN_ACT_LO = IN_LVL_LO + LEVEL_W;
    localparam int IN_BITS   = IN_ACT_LO + ACT_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        CMD_NONE        = 3'd0,
        CMD_ESTOP       = 3'd1,
        CMD_START       = 3'd2,
        CMD_RESET_START = 3'd3,
        CMD_MULTI       = 3'd4
    } t_cmd;

    // Field offsets inside the result word
    localparam int OUT_RAN_LO = 0;
    localparam int OUT_MSK_LO = OUT_RAN_LO + 1;
    localparam int OUT_CMD_LO = OUT_MSK_LO + MASK_W;
    localparam int OUT_MIS_LO = OUT_CMD_LO + $bits(t_cmd);
    localparam int OUT_BITS   = OUT_MIS_LO + MIS_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ACT_IDLE   = 2'd0,
        ACT_MOTION = 2'd1,
        ACT_DONE   = 2'd2,
        ACT_SPARE  = 2'd3
    } t_act;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_INIT = 1'b1
    } t_op;

    typedef enum logic {
        CFG_DEBOUNCE = 1'b0,
        CFG_PERIOD   = 1'b1
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] PERIOD_RST   = 16'd10;

    // State write strobes for one processed word
    typedef struct packed {
        logic init_we;  // init word: load levels and time stamps
        logic eval_we;  // due tick: run the debounce update
    } t_upd_ctl;

endpackage

// ===== rtl/core/bdq_sched.sv =====
// ----------------------------------------------------------------------------
// bdq_sched
// Catch-up task scheduler: decides whether a tick is due and keeps the last
// task time stamp, resyncing when still a full period or more behind after advancing.
// ----------------------------------------------------------------------------
module bdq_sched (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bdq_pkg::t_upd_ctl           i_ctl,
    input  logic [bdq_pkg::TIME_W-1:0]  i_now,
    input  logic [bdq_pkg::CFG_W-1:0]   i_period,
    output logic                        o_due
);

    logic [bdq_pkg::TIME_W-1:0] r_last;
    logic [bdq_pkg::TIME_W-1:0] n_last;
    logic [bdq_pkg::TIME_W-1:0] period_ext;
    logic [bdq_pkg::TIME_W-1:0] step_last;

    assign period_ext = {{(bdq_pkg::TIME_W - bdq_pkg::CFG_W){1'b0}}, i_period};
    assign o_due      = (i_now - r_last) >= period_ext;
    assign step_last  = r_last + period_ext;

    always_comb begin
        n_last = r_last;
        if (i_ctl.init_we) begin
            n_last = i_now;
        end else if (i_ctl.eval_we) begin
            // advance one period, resync when still a period behind
            n_last = ((i_now - step_last) >= period_ext) ? i_now : step_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else begin
            r_last <= n_last;
        end
    end

endmodule

// ===== rtl/core/bdq_lane.sv =====
// ----------------------------------------------------------------------------
// bdq_lane
// One button's debounce state: raw level, stable level, change time stamp.
// Flags a stable press edge on an evaluated tick.
// ----------------------------------------------------------------------------
module bdq_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bdq_pkg::t_upd_ctl           i_ctl,
    input  logic                        i_lvl,
    input  logic [bdq_pkg::TIME_W-1:0]  i_now,
    input  logic [bdq_pkg::CFG_W-1:0]   i_debounce,
    output logic                        o_press
);

    logic                       r_raw;
    logic                       r_stable;
    logic [bdq_pkg::TIME_W-1:0] r_chg;
    logic                       n_raw;
    logic                       n_stable;
    logic [bdq_pkg::TIME_W-1:0] n_chg;
    logic                       raw_moved;
    logic [bdq_pkg::TIME_W-1:0] chg_eff;
    logic                       settled;

    assign raw_moved = i_lvl != r_raw;
    assign chg_eff   = raw_moved ? i_now : r_chg;
    assign settled   = (i_lvl != r_stable) &&
        ((i_now - chg_eff) >=
         {{(bdq_pkg::TIME_W - bdq_pkg::CFG_W){1'b0}}, i_debounce});

    always_comb begin
        n_raw    = r_raw;
        n_stable = r_stable;
        n_chg    = r_chg;
        o_press  = 1'b0;
        if (i_ctl.init_we) begin
            n_raw    = i_lvl;
            n_stable = i_lvl;
            n_chg    = i_now;
        end else if (i_ctl.eval_we) begin
            n_raw = i_lvl;
            n_chg = chg_eff;
            if (settled) begin
                n_stable = i_lvl;
                o_press  = i_lvl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw    <= 1'b0;
            r_stable <= 1'b0;
            r_chg    <= '0;
        end else begin
            r_raw    <= n_raw;
            r_stable <= n_stable;
            r_chg    <= n_chg;
        end
    end

endmodule

// ===== rtl/core/bdq_cmd.sv =====
// ----------------------------------------------------------------------------
// bdq_cmd
// Command encoder: press edges and activity class to command and mission.
// ----------------------------------------------------------------------------
module bdq_cmd #(
    parameter int BUTTONS = 3
) (
    input  logic [BUTTONS-1:0]          i_press,
    input  logic [bdq_pkg::ACT_W-1:0]   i_act,
    output logic [bdq_pkg::MASK_W-1:0]  o_mask,
    output bdq_pkg::t_cmd               o_cmd,
    output logic [bdq_pkg::MIS_W-1:0]   o_mission
);

    logic [BUTTONS+bdq_pkg::MASK_W-1:0] press_pad;
    logic                               any_press;
    logic                               multi;
    logic [2:0]                         first;

    assign press_pad = {{bdq_pkg::MASK_W{1'b0}}, i_press};
    assign o_mask    = press_pad[bdq_pkg::MASK_W-1:0];
    assign any_press = |i_press;
    assign multi     = |(i_press & (i_press - BUTTONS'(1)));

    // lowest pressed index wins
    always_comb begin
        first = 3'd0;
        for (int i = BUTTONS - 1; i >= 0; i--) begin
            if (i_press[i]) begin
                first = 3'(i);
            end
        end
    end

    always_comb begin
        o_cmd     = bdq_pkg::CMD_NONE;
        o_mission = '0;
        if (multi) begin
            o_cmd = bdq_pkg::CMD_MULTI;
        end else if (any_press) begin
            case (bdq_pkg::t_act'(i_act))
                bdq_pkg::ACT_MOTION: begin
                    o_cmd = bdq_pkg::CMD_ESTOP;
                end
                bdq_pkg::ACT_DONE: begin
                    o_cmd     = bdq_pkg::CMD_RESET_START;
                    o_mission = first[bdq_pkg::MIS_W-1:0];
                end
                default: begin
                    o_cmd     = bdq_pkg::CMD_START;
                    o_mission = first[bdq_pkg::MIS_W-1:0];
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/debounced_button_command_qualifier.sv =====
// ----------------------------------------------------------------------------
// debounced_button_command_qualifier
// Debounces push buttons on scheduled ticks and turns single press edges
// into start, reset-then-start or emergency stop commands, and multiple presses into an error.
// ----------------------------------------------------------------------------
// Path: an accepted input word passes the input register, then the result register.
// Throughput: one word per cycle; the result register advances when it is empty or
//   being taken, and the input register when it is empty or the result register advances.
// Reset: synchronous, active low; clears button state, the task time stamp,
//   both valid flags, and loads debounce 20 ms and task period 10 ms.
// ----------------------------------------------------------------------------
module debounced_button_command_qualifier #(
    parameter int BUTTONS = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [bdq_pkg::CFG_W-1:0]         i_cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] now_ms, [34:32] pressed_levels, [36:35] car_activity, rest zero
    input  logic [bdq_pkg::IN_DATA_W-1:0]     s_tdata,
    // [0] op
    input  logic                              s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] task_ran, [3:1] press_mask, [6:4] command, [8:7] mission, rest zero
    output logic [bdq_pkg::OUT_DATA_W-1:0]    m_tdata
);

    // configuration
    logic [bdq_pkg::CFG_W-1:0]   r_debounce;
    logic [bdq_pkg::CFG_W-1:0]   r_period;

    // input register
    logic                        r_in_valid;
    logic                        r_in_op;
    logic [bdq_pkg::TIME_W-1:0]  r_in_now;
    logic [bdq_pkg::LEVEL_W-1:0] r_in_lvl;
    logic [bdq_pkg::ACT_W-1:0]   r_in_act;

    // result register
    logic                        r_out_valid;
    logic                        r_out_ran;
    logic [bdq_pkg::MASK_W-1:0]  r_out_mask;
    bdq_pkg::t_cmd               r_out_cmd;
    logic [bdq_pkg::MIS_W-1:0]   r_out_mis;

    logic                        advance;
    logic                        fire;
    logic                        due;
    bdq_pkg::t_upd_ctl           upd;
    logic [BUTTONS+bdq_pkg::LEVEL_W-1:0] lvl_pad;
    logic [BUTTONS-1:0]          press;
    logic [bdq_pkg::MASK_W-1:0]  n_mask;
    bdq_pkg::t_cmd               n_cmd;
    logic [bdq_pkg::MIS_W-1:0]   n_mis;

    // Advance the pipe whenever the result slot is free or being drained
    assign advance  = !r_out_valid || m_tready;
    assign s_tready = !r_in_valid || advance;
    assign fire     = r_in_valid && advance;

    // Write state only for the word that moves into the result register
    assign upd.init_we = fire && (bdq_pkg::t_op'(r_in_op) == bdq_pkg::OP_INIT);
    assign upd.eval_we = fire && (bdq_pkg::t_op'(r_in_op) == bdq_pkg::OP_TICK) && due;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= bdq_pkg::DEBOUNCE_RST;
            r_period   <= bdq_pkg::PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (bdq_pkg::t_cfg_idx'(i_cfg_idx))
                bdq_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                bdq_pkg::CFG_PERIOD:   r_period   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture an input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_op  <= s_tuser;
            r_in_now <= s_tdata[bdq_pkg::IN_NOW_LO +: bdq_pkg::TIME_W];
            r_in_lvl <= s_tdata[bdq_pkg::IN_LVL_LO +: bdq_pkg::LEVEL_W];
            r_in_act <= s_tdata[bdq_pkg::IN_ACT_LO +: bdq_pkg::ACT_W];
        end
    end

    bdq_sched u_sched (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (upd),
        .i_now    (r_in_now),
        .i_period (r_period),
        .o_due    (due)
    );

    // Buttons past the level field always read as released
    assign lvl_pad = {{BUTTONS{1'b0}}, r_in_lvl};

    for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
        bdq_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (upd),
            .i_lvl      (lvl_pad[g]),
            .i_now      (r_in_now),
            .i_debounce (r_debounce),
            .o_press    (press[g])
        );
    end

    bdq_cmd #(
        .BUTTONS (BUTTONS)
    ) u_cmd (
        .i_press   (press),
        .i_act     (r_in_act),
        .o_mask    (n_mask),
        .o_cmd     (n_cmd),
        .o_mission (n_mis)
    );

    // Result register; press edges are zero unless the tick was evaluated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_ran  <= upd.eval_we;
            r_out_mask <= n_mask;
            r_out_cmd  <= n_cmd;
            r_out_mis  <= n_mis;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(bdq_pkg::OUT_DATA_W - bdq_pkg::OUT_BITS){1'b0}},
                       r_out_mis, r_out_cmd, r_out_mask, r_out_ran};

    // A word in the input stage that moves always lands in the result stage
    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed word did not reach result register");

    // No press edge or command from a word that skipped evaluation
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ran) |->
            (r_out_mask == '0 && r_out_cmd == bdq_pkg::CMD_NONE && r_out_mis == '0))
        else $error("result without evaluation carries a command");

    // Multiple press error means more than one bit is set in the press mask
    a_multi_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cmd == bdq_pkg::CMD_MULTI) |-> ($countones(r_out_mask) > 1))
        else $error("multiple press error with fewer than two edges");

    // Start commands point at the one pressed button
    a_mission_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_cmd == bdq_pkg::CMD_START ||
                         r_out_cmd == bdq_pkg::CMD_RESET_START)) |->
            ($onehot(r_out_mask) && r_out_mask[r_out_mis] == 1'b1))
        else $error("mission does not match press edge");

    // An init word never reports evaluation in the next result
    a_init_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd.init_we |=> !r_out_ran)
        else $error("init word reported as evaluated tick");

endmodule
